// ===== hw/rtl/dtsw_pkg.sv =====
// Shared types and constants of the devicetree structure token walker.
// Holds event codes, walk modes, token codes and the result bundle.
// No dependencies.
`timescale 1ns / 1ps

package dtsw_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned LeftW = 30;

  localparam logic [WordW-1:0] TokBeginNode = 32'h0000_0001;
  localparam logic [WordW-1:0] TokEndNode   = 32'h0000_0002;
  localparam logic [WordW-1:0] TokProp      = 32'h0000_0003;
  localparam logic [WordW-1:0] TokNop       = 32'h0000_0004;
  localparam logic [WordW-1:0] TokEnd       = 32'h0000_0009;
  localparam logic [WordW-1:0] DtMagic      = 32'hd00d_feed;

  typedef enum logic [3:0] {
    EV_SKIP       = 4'd0,
    EV_NODE_BEGIN = 4'd1,
    EV_NAME_WORD  = 4'd2,
    EV_NODE_END   = 4'd3,
    EV_NOP        = 4'd4,
    EV_PROP_HDR   = 4'd5,
    EV_PROP_VALUE = 4'd6,
    EV_END        = 4'd7,
    EV_BAD_TOKEN  = 4'd8,
    EV_BAD_MAGIC  = 4'd9
  } event_e;

  typedef enum logic [2:0] {
    MODE_STOPPED = 3'd0,
    MODE_TOKEN   = 3'd1,
    MODE_NAME    = 3'd2,
    MODE_PLEN    = 3'd3,
    MODE_POFF    = 3'd4,
    MODE_VALUE   = 3'd5
  } mode_e;

  typedef struct packed {
    event_e           event_res;
    logic [WordW-1:0] prop_length;
    logic [WordW-1:0] name_offset;
    logic [WordW-1:0] value_word;
    logic             value_last;
  } res_t;

  function automatic logic [WordW-1:0] swap32(input logic [WordW-1:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

endpackage

// ===== hw/rtl/dtsw_walk.sv =====
// Token walk state and per-word decode of the structure block.
// Holds walk mode, value word count, property length and name offset.
// Depends on dtsw_pkg.
`timescale 1ns / 1ps

module dtsw_walk (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [dtsw_pkg::WordW-1:0] word_i,
  input  logic                      first_i,
  input  logic                      magic_ok_i,
  output dtsw_pkg::res_t            res_o
);

  dtsw_pkg::mode_e            mode_q, mode_d;
  logic [dtsw_pkg::LeftW-1:0] left_q, left_d;
  logic [dtsw_pkg::WordW-1:0] len_q, len_d;
  logic [dtsw_pkg::WordW-1:0] off_q, off_d;
  logic [dtsw_pkg::WordW-1:0] host;
  logic [dtsw_pkg::WordW-1:0] len_m1;
  logic                       zero_byte;
  dtsw_pkg::event_e           tok_ev;
  dtsw_pkg::mode_e            tok_mode;

  assign host      = dtsw_pkg::swap32(word_i);
  assign len_m1    = len_q - 32'd1;
  assign zero_byte = (word_i[31:24] == 8'd0) || (word_i[23:16] == 8'd0) ||
                     (word_i[15:8] == 8'd0) || (word_i[7:0] == 8'd0);

  always_comb begin
    unique case (host)
      dtsw_pkg::TokBeginNode: begin
        tok_ev   = dtsw_pkg::EV_NODE_BEGIN;
        tok_mode = dtsw_pkg::MODE_NAME;
      end
      dtsw_pkg::TokEndNode: begin
        tok_ev   = dtsw_pkg::EV_NODE_END;
        tok_mode = dtsw_pkg::MODE_TOKEN;
      end
      dtsw_pkg::TokProp: begin
        tok_ev   = dtsw_pkg::EV_SKIP;
        tok_mode = dtsw_pkg::MODE_PLEN;
      end
      dtsw_pkg::TokNop: begin
        tok_ev   = dtsw_pkg::EV_NOP;
        tok_mode = dtsw_pkg::MODE_TOKEN;
      end
      dtsw_pkg::TokEnd: begin
        tok_ev   = dtsw_pkg::EV_END;
        tok_mode = dtsw_pkg::MODE_STOPPED;
      end
      default: begin
        tok_ev   = dtsw_pkg::EV_BAD_TOKEN;
        tok_mode = dtsw_pkg::MODE_STOPPED;
      end
    endcase
  end

  always_comb begin
    mode_d = mode_q;
    left_d = left_q;
    len_d  = len_q;
    off_d  = off_q;
    res_o  = '{event_res: dtsw_pkg::EV_SKIP, prop_length: '0, name_offset: '0,
               value_word: '0, value_last: 1'b0};
    if (first_i) begin
      left_d = '0;
      len_d  = '0;
      off_d  = '0;
      if (!magic_ok_i) begin
        mode_d          = dtsw_pkg::MODE_STOPPED;
        res_o.event_res = dtsw_pkg::EV_BAD_MAGIC;
      end else begin
        mode_d          = tok_mode;
        res_o.event_res = tok_ev;
      end
    end else begin
      unique case (mode_q)
        dtsw_pkg::MODE_TOKEN: begin
          mode_d          = tok_mode;
          res_o.event_res = tok_ev;
        end
        dtsw_pkg::MODE_NAME: begin
          res_o.event_res = dtsw_pkg::EV_NAME_WORD;
          if (zero_byte) begin
            mode_d = dtsw_pkg::MODE_TOKEN;
          end
        end
        dtsw_pkg::MODE_PLEN: begin
          len_d  = host;
          mode_d = dtsw_pkg::MODE_POFF;
        end
        dtsw_pkg::MODE_POFF: begin
          off_d             = host;
          res_o.event_res   = dtsw_pkg::EV_PROP_HDR;
          res_o.prop_length = len_q;
          res_o.name_offset = host;
          if (len_q == '0) begin
            mode_d = dtsw_pkg::MODE_TOKEN;
          end else begin
            left_d = len_m1[31:2];
            mode_d = dtsw_pkg::MODE_VALUE;
          end
        end
        dtsw_pkg::MODE_VALUE: begin
          res_o.event_res   = dtsw_pkg::EV_PROP_VALUE;
          res_o.prop_length = len_q;
          res_o.name_offset = off_q;
          res_o.value_word  = host;
          if (left_q == '0) begin
            res_o.value_last = 1'b1;
            mode_d           = dtsw_pkg::MODE_TOKEN;
          end else begin
            left_d = left_q - 30'd1;
          end
        end
        default: begin
          mode_d = mode_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= dtsw_pkg::MODE_STOPPED;
      left_q <= '0;
      len_q  <= '0;
      off_q  <= '0;
    end else if (step_i) begin
      mode_q <= mode_d;
      left_q <= left_d;
      len_q  <= len_d;
      off_q  <= off_d;
    end
  end

endmodule

// ===== hw/rtl/dtsw_out.sv =====
// Result register of the token walker, facing the output channel.
// Loads a new result whenever the held one is taken or empty.
// Depends on dtsw_pkg.
`timescale 1ns / 1ps

module dtsw_out (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  dtsw_pkg::res_t res_i,
  input  logic           stall_i,
  output logic           ready_o,
  output logic           valid_o,
  output dtsw_pkg::res_t res_o
);

  logic           valid_q, valid_d;
  dtsw_pkg::res_t res_q;

  assign ready_o = !valid_q || !stall_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ===== hw/rtl/devicetree_struct_token_walker_unit.sv =====
// Top level of the devicetree structure block token walker.
// Input word register, header magic register, walk decode and result register.
// Depends on dtsw_pkg, dtsw_walk and dtsw_out.
`timescale 1ns / 1ps

// Usage:
//   Write the header magic word, as stored (big-endian), through cfg_we_i and
//   cfg_wdata_i while the block is idle. Then stream structure-block words on
//   the input channel, first_i set on the first word of a walk. A word is
//   taken when in_valid_i is high and in_stall_o low; every word gives exactly
//   one result word on the output channel, taken when out_valid_o is high and
//   out_stall_i low.
//   Path: a result passes from the input register through the combinational
//   decode into the result register, and is offered once it is held there.
//   Throughput: one word per cycle while the output is not stalled, set by the
//   combinational decode between the two registers.
//   Reset clears the magic register, stops the walk and empties both stages.
//   When the receiver stalls, the result register holds its word; the input
//   register takes at most one more word, after which in_stall_o stays high
//   until the output moves again.
module devicetree_struct_token_walker_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] word_i,
  input  logic        first_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  event_res_o,
  output logic [31:0] prop_length_o,
  output logic [31:0] name_offset_o,
  output logic [31:0] value_word_o,
  output logic        value_last_o
);

  logic [31:0]    magic_q;
  logic           magic_ok;
  logic           in_valid_q, in_valid_d;
  logic [31:0]    word_q;
  logic           first_q;
  logic           out_ready;
  logic           advance;
  logic           in_take;
  dtsw_pkg::res_t res_step;
  dtsw_pkg::res_t res_held;

  assign magic_ok   = dtsw_pkg::swap32(magic_q) == dtsw_pkg::DtMagic;
  assign advance    = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q    <= '0;
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
      if (cfg_we_i) begin
        magic_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      word_q  <= word_i;
      first_q <= first_i;
    end
  end

  dtsw_walk u_walk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .word_i    (word_q),
    .first_i   (first_q),
    .magic_ok_i(magic_ok),
    .res_o     (res_step)
  );

  dtsw_out u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (advance),
    .res_i  (res_step),
    .stall_i(out_stall_i),
    .ready_o(out_ready),
    .valid_o(out_valid_o),
    .res_o  (res_held)
  );

  assign event_res_o   = res_held.event_res;
  assign prop_length_o = res_held.prop_length;
  assign name_offset_o = res_held.name_offset;
  assign value_word_o  = res_held.value_word;
  assign value_last_o  = res_held.value_last;

endmodule

// ===== tb/devicetree_struct_token_walker_unit_tb.sv =====
// Self-checking testbench of the devicetree structure token walker unit.
// Streams directed and random structure-block words through a walk scoreboard.
// Depends on dtsw_pkg and devicetree_struct_token_walker_unit.
`timescale 1ns / 1ps

module devicetree_struct_token_walker_unit_tb;

  localparam logic [31:0] StoredMagic = 32'hedfe_0dd0;
  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned PhaseWords = 230;

  class dt_walk_model;
    logic [31:0]                magic_raw;
    dtsw_pkg::mode_e            mode;
    logic [dtsw_pkg::LeftW-1:0] words_left;
    logic [31:0]                cur_len;
    logic [31:0]                cur_off;
    dtsw_pkg::res_t             expected_events[$];
    int unsigned                errors;

    function new();
      magic_raw  = '0;
      mode       = dtsw_pkg::MODE_STOPPED;
      words_left = '0;
      cur_len    = '0;
      cur_off    = '0;
      errors     = 0;
    endfunction

    static function logic [31:0] byte_rev(logic [31:0] w);
      return ((w & 32'hFF00_0000) >> 24) | ((w & 32'h00FF_0000) >> 8) |
             ((w & 32'h0000_FF00) << 8) | ((w & 32'h0000_00FF) << 24);
    endfunction

    function void set_magic(logic [31:0] v);
      magic_raw = v;
    endfunction

    function int pending();
      return expected_events.size();
    endfunction

    function dtsw_pkg::event_e take_token(logic [31:0] host);
      case (host)
        dtsw_pkg::TokBeginNode: begin
          mode = dtsw_pkg::MODE_NAME;
          return dtsw_pkg::EV_NODE_BEGIN;
        end
        dtsw_pkg::TokEndNode: begin
          mode = dtsw_pkg::MODE_TOKEN;
          return dtsw_pkg::EV_NODE_END;
        end
        dtsw_pkg::TokProp: begin
          mode = dtsw_pkg::MODE_PLEN;
          return dtsw_pkg::EV_SKIP;
        end
        dtsw_pkg::TokNop: begin
          mode = dtsw_pkg::MODE_TOKEN;
          return dtsw_pkg::EV_NOP;
        end
        dtsw_pkg::TokEnd: begin
          mode = dtsw_pkg::MODE_STOPPED;
          return dtsw_pkg::EV_END;
        end
        default: begin
          mode = dtsw_pkg::MODE_STOPPED;
          return dtsw_pkg::EV_BAD_TOKEN;
        end
      endcase
    endfunction

    function void note_word(logic [31:0] raw, logic first);
      dtsw_pkg::res_t e;
      logic [31:0]    host;
      host = byte_rev(raw);
      e = '0;
      if (first) begin
        words_left = '0;
        cur_len    = '0;
        cur_off    = '0;
        if (byte_rev(magic_raw) != dtsw_pkg::DtMagic) begin
          mode = dtsw_pkg::MODE_STOPPED;
          e.event_res = dtsw_pkg::EV_BAD_MAGIC;
        end else begin
          e.event_res = take_token(host);
        end
      end else begin
        case (mode)
          dtsw_pkg::MODE_TOKEN: e.event_res = take_token(host);
          dtsw_pkg::MODE_NAME: begin
            e.event_res = dtsw_pkg::EV_NAME_WORD;
            if (raw[31:24] == 8'h00 || raw[23:16] == 8'h00 ||
                raw[15:8] == 8'h00 || raw[7:0] == 8'h00) begin
              mode = dtsw_pkg::MODE_TOKEN;
            end
          end
          dtsw_pkg::MODE_PLEN: begin
            cur_len = host;
            mode = dtsw_pkg::MODE_POFF;
          end
          dtsw_pkg::MODE_POFF: begin
            cur_off = host;
            e.event_res   = dtsw_pkg::EV_PROP_HDR;
            e.prop_length = cur_len;
            e.name_offset = cur_off;
            if (cur_len == 32'd0) begin
              mode = dtsw_pkg::MODE_TOKEN;
            end else begin
              words_left = dtsw_pkg::LeftW'((cur_len - 32'd1) >> 2);
              mode = dtsw_pkg::MODE_VALUE;
            end
          end
          dtsw_pkg::MODE_VALUE: begin
            e.event_res   = dtsw_pkg::EV_PROP_VALUE;
            e.prop_length = cur_len;
            e.name_offset = cur_off;
            e.value_word  = host;
            if (words_left == '0) begin
              e.value_last = 1'b1;
              mode = dtsw_pkg::MODE_TOKEN;
            end else begin
              words_left = words_left - 1'b1;
            end
          end
          default: e.event_res = dtsw_pkg::EV_SKIP;
        endcase
      end
      expected_events.push_back(e);
    endfunction

    function void compare_field(string field, logic [31:0] exp, logic [31:0] act);
      if (exp !== act) begin
        errors++;
        $display("%0t %s: expected %h, got %h", $time, field, exp, act);
      end
    endfunction

    function void check_event(dtsw_pkg::res_t got);
      dtsw_pkg::res_t e;
      if (expected_events.size() == 0) begin
        errors++;
        $display("%0t result with none due: expected nothing, got event %0d",
                 $time, got.event_res);
        return;
      end
      e = expected_events.pop_front();
      compare_field("event_res", 32'(e.event_res), 32'(got.event_res));
      compare_field("prop_length", e.prop_length, got.prop_length);
      compare_field("name_offset", e.name_offset, got.name_offset);
      compare_field("value_word", e.value_word, got.value_word);
      compare_field("value_last", 32'(e.value_last), 32'(got.value_last));
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [31:0] word_i      = '0;
  logic        first_i     = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [3:0]  event_res_o;
  logic [31:0] prop_length_o;
  logic [31:0] name_offset_o;
  logic [31:0] value_word_o;
  logic        value_last_o;

  dt_walk_model walk_sb = new();
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;
  int unsigned  words_sent = 0;
  int unsigned  quiet_cycles = 0;

  devicetree_struct_token_walker_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .word_i       (word_i),
    .first_i      (first_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .event_res_o  (event_res_o),
    .prop_length_o(prop_length_o),
    .name_offset_o(name_offset_o),
    .value_word_o (value_word_o),
    .value_last_o (value_last_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    dtsw_pkg::res_t got;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        walk_sb.note_word(word_i, first_i);
      end
      if (out_valid_o && !out_stall_i) begin
        got.event_res   = dtsw_pkg::event_e'(event_res_o);
        got.prop_length = prop_length_o;
        got.name_offset = name_offset_o;
        got.value_word  = value_word_o;
        got.value_last  = value_last_o;
        walk_sb.check_event(got);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QuietLimit) begin
        $display("tb: failure");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_word(input logic [31:0] w, input logic f);
    logic stalled;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    word_i     <= w;
    first_i    <= f;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    words_sent++;
  endtask

  task automatic send_token(input logic [31:0] tok);
    send_word(dt_walk_model::byte_rev(tok), 1'b0);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (walk_sb.pending() != 0);
    @(posedge clk_i);
  endtask

  task automatic write_magic(input logic [31:0] v);
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (3) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    walk_sb.set_magic(v);
  endtask

  function automatic logic [31:0] name_word(input bit terminal);
    logic [31:0] w;
    for (int i = 0; i < 4; i++) begin
      w[i*8 +: 8] = 8'($urandom_range(1, 255));
    end
    if (terminal) begin
      w[$urandom_range(0, 3)*8 +: 8] = 8'h00;
      if ($urandom_range(0, 3) == 0) w[$urandom_range(0, 3)*8 +: 8] = 8'h00;
    end
    return w;
  endfunction

  task automatic send_name();
    repeat ($urandom_range(0, 2)) send_word(name_word(1'b0), 1'b0);
    send_word(name_word(1'b1), 1'b0);
  endtask

  task automatic send_prop();
    logic [31:0] len;
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 14) len = $urandom_range(0, 12);
    else len = $urandom_range(13, 48);
    send_token(dtsw_pkg::TokProp);
    send_word(dt_walk_model::byte_rev(len), 1'b0);
    send_word($urandom(), 1'b0);
    repeat ((len + 3) / 4) send_word($urandom(), 1'b0);
  endtask

  task automatic send_node(input bit root, input int depth);
    if (root) send_word(dt_walk_model::byte_rev(dtsw_pkg::TokBeginNode), 1'b1);
    else send_token(dtsw_pkg::TokBeginNode);
    send_name();
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 4) == 0) send_token(dtsw_pkg::TokNop);
      send_prop();
    end
    if (depth < 2) begin
      repeat ($urandom_range(0, 2)) send_node(1'b0, depth + 1);
    end
    send_token(dtsw_pkg::TokEndNode);
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 3))
      0: repeat ($urandom_range(1, 6)) send_word($urandom(), $urandom_range(0, 7) == 0);
      1: begin
        send_word(dt_walk_model::byte_rev(dtsw_pkg::TokBeginNode), 1'b1);
        send_name();
        send_token($urandom_range(0, 15));
      end
      2: begin
        send_word(dt_walk_model::byte_rev(dtsw_pkg::TokBeginNode), 1'b1);
        send_name();
        send_token(dtsw_pkg::TokProp);
        send_word($urandom(), 1'b0);
        send_word($urandom(), 1'b0);
        repeat ($urandom_range(1, 3)) send_word($urandom(), 1'b0);
      end
      default: send_token($urandom());
    endcase
  endtask

  task automatic run_directed();
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(dt_walk_model::byte_rev(dtsw_pkg::TokBeginNode), 1'b1);
    write_magic(32'hFFFF_FFFF);
    send_word(32'h0000_0000, 1'b1);
    write_magic(StoredMagic);
    send_word(dt_walk_model::byte_rev(dtsw_pkg::TokBeginNode), 1'b1);
    send_word(32'h6162_6364, 1'b0);
    send_word(32'h6566_6700, 1'b0);
    send_token(dtsw_pkg::TokProp);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_token(dtsw_pkg::TokProp);
    send_word(dt_walk_model::byte_rev(32'd5), 1'b0);
    send_word(dt_walk_model::byte_rev(32'h10), 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_token(dtsw_pkg::TokNop);
    send_token(dtsw_pkg::TokBeginNode);
    send_word(32'h0041_4243, 1'b0);
    send_token(dtsw_pkg::TokProp);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'h1234_5678, 1'b0);
    send_word(dt_walk_model::byte_rev(dtsw_pkg::TokEndNode), 1'b1);
    send_token(32'h0000_00FF);
    send_word(32'h0000_0000, 1'b0);
    send_word(dt_walk_model::byte_rev(dtsw_pkg::TokBeginNode), 1'b1);
    send_word(32'h0000_0000, 1'b0);
    send_token(dtsw_pkg::TokEndNode);
    send_token(dtsw_pkg::TokEnd);
    send_word(dt_walk_model::byte_rev(dtsw_pkg::TokBeginNode), 1'b0);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 20;
    recv_idle_pct = 74;
    run_directed();
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle_pct = 74;
        recv_idle_pct = 20;
      end else if (ph == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_magic($urandom());
      repeat (6) send_word($urandom(), $urandom_range(0, 1));
      write_magic(StoredMagic);
      while (words_sent < PhaseWords * (ph + 1)) begin
        if ($urandom_range(0, 4) == 0) send_noise();
        else begin
          send_node(1'b1, 0);
          send_token(dtsw_pkg::TokEnd);
        end
      end
    end
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (walk_sb.errors == 0 && walk_sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/dtsw_pkg.sv
hw/rtl/dtsw_walk.sv
hw/rtl/dtsw_out.sv
hw/rtl/devicetree_struct_token_walker_unit.sv
tb/devicetree_struct_token_walker_unit_tb.sv
